// ----- hdl/raster_op_pixel_blitter_defines.svh -----
// assertion macros shared by the blitter rtl
`ifndef RASTER_OP_PIXEL_BLITTER_DEFINES_SVH
`define RASTER_OP_PIXEL_BLITTER_DEFINES_SVH

// same-cycle implication
`define ROP_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rop check failed: same-cycle implication");

// next-cycle implication
`define ROP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rop check failed: next-cycle implication");

`endif

// ----- hdl/rop_pkg.sv -----
`default_nettype none

package rop_pkg;

   localparam int PIXEL_BITS     = 32;
   localparam int TILE_ADDR_BITS = 12;
   localparam int CSR_INDEX_BITS = 3;
   localparam int TILE_DIM_BITS  = 13;
   localparam int TILE_POS_BITS  = 12;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   localparam pixel_type MASK_8      = 32'h0000_00ff;
   localparam pixel_type MASK_16     = 32'h0000_ffff;
   localparam pixel_type MASK_32     = 32'hffff_ffff;
   localparam pixel_type KEY_MASK_24 = 32'h00ff_ffff;
   localparam pixel_type PIXEL_ZERO  = 32'h0000_0000;

   typedef enum logic [1:0] {
      SRC_SOLID  = 2'd0,
      SRC_TILE   = 2'd1,
      SRC_STREAM = 2'd2,
      SRC_KEYED  = 2'd3
   } src_kind_type;

   typedef enum logic [1:0] {
      DEPTH_8  = 2'd0,
      DEPTH_16 = 2'd1,
      DEPTH_32 = 2'd2
   } depth_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROP_CODE        = 3'd0,
      CSR_PIXEL_DEPTH     = 3'd1,
      CSR_SOURCE_KIND     = 3'd2,
      CSR_REFERENCE_COLOR = 3'd3,
      CSR_PAT_WIDTH       = 3'd4,
      CSR_PAT_HEIGHT      = 3'd5,
      CSR_PAT_ORIGIN_X    = 3'd6,
      CSR_PAT_ORIGIN_Y    = 3'd7
   } csr_index_type;

   typedef enum logic {
      MODE_TILE_LOAD = 1'b0,
      MODE_PIXEL     = 1'b1
   } mode_type;

   localparam logic [3:0] ROP_COPY = 4'd3;

   typedef struct packed {
      logic [3:0]               rop_code;
      logic [1:0]               pixel_depth;
      src_kind_type             source_kind;
      pixel_type                reference_color;
      logic [TILE_DIM_BITS-1:0] pat_width;
      logic [TILE_DIM_BITS-1:0] pat_height;
      logic [TILE_POS_BITS-1:0] pat_origin_x;
      logic [TILE_POS_BITS-1:0] pat_origin_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rop_code:        ROP_COPY,
      pixel_depth:     DEPTH_32,
      source_kind:     SRC_STREAM,
      reference_color: PIXEL_ZERO,
      pat_width:       13'd1,
      pat_height:      13'd1,
      pat_origin_x:    12'd0,
      pat_origin_y:    12'd0
   };

   typedef struct packed {
      logic reload;
      logic step;
      logic end_of_row;
   } walk_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/rop_channels.sv -----
`default_nettype none

interface rop_req_if;
   import rop_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [TILE_ADDR_BITS-1:0] tile_address;
   pixel_type                 dst_pixel;
   pixel_type                 src_pixel;
   logic                      end_of_row;

   modport source (
      output valid, mode, tile_address, dst_pixel, src_pixel, end_of_row,
      input  ready
   );
   modport sink (
      input  valid, mode, tile_address, dst_pixel, src_pixel, end_of_row,
      output ready
   );
endinterface

interface rop_rsp_if;
   import rop_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type result_pixel;
   logic      write_enable;
   logic      row_done;

   modport source (
      output valid, result_pixel, write_enable, row_done,
      input  ready
   );
   modport sink (
      input  valid, result_pixel, write_enable, row_done,
      output ready
   );
endinterface

interface rop_csr_if;
   import rop_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   pixel_type                 data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/rop_tile_walker.sv -----
`default_nettype none

module rop_tile_walker #(
   parameter int TILE_PIXELS = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rop_pkg::cfg_type               cfg_next,
   input  rop_pkg::walk_ctl_type          ctl,
   output logic [$clog2(TILE_PIXELS)-1:0] tile_addr
);
   import rop_pkg::*;

   localparam int AW = $clog2(TILE_PIXELS);
   localparam int CW = TILE_DIM_BITS;
   localparam int SW = ((AW > CW) ? AW : CW) + 1;
   localparam int PW = 2 * CW;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] row_ff, row_in;
   logic [AW-1:0] base_ff, base_in;
   logic [CW:0]   col_inc;
   logic [CW:0]   row_inc;
   logic [SW-1:0] base_sum;
   logic [SW-1:0] addr_sum;
   logic [PW-1:0] reload_prod;

   always_comb begin
      col_inc     = {1'b0, col_ff} + (CW+1)'(1);
      row_inc     = {1'b0, row_ff} + (CW+1)'(1);
      // row base steps by one tile width per row, wrapping with the store size
      base_sum    = SW'(base_ff) + SW'(cfg_next.pat_width);
      reload_prod = PW'(cfg_next.pat_origin_y) * PW'(cfg_next.pat_width);
      addr_sum    = SW'(base_ff) + SW'(col_ff);
      tile_addr   = addr_sum[AW-1:0];
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (ctl.reload) begin
         col_in  = CW'(cfg_next.pat_origin_x);
         row_in  = CW'(cfg_next.pat_origin_y);
         base_in = reload_prod[AW-1:0];
      end else if (ctl.step) begin
         if (ctl.end_of_row) begin
            col_in = CW'(cfg_next.pat_origin_x);
            if (row_inc >= {1'b0, cfg_next.pat_height}) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = row_inc[CW-1:0];
               base_in = base_sum[AW-1:0];
            end
         end else if (col_inc >= {1'b0, cfg_next.pat_width}) begin
            col_in = '0;
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/rop_tile_store.sv -----
`default_nettype none

module rop_tile_store #(
   parameter int TILE_PIXELS = 4096
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TILE_PIXELS)-1:0] wr_addr,
   input  rop_pkg::pixel_type             wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(TILE_PIXELS)-1:0] rd_addr,
   output rop_pkg::pixel_type             rd_data
);
   import rop_pkg::*;

   pixel_type mem [TILE_PIXELS];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/rop_pixel_alu.sv -----
`default_nettype none

module rop_pixel_alu (
   input  rop_pkg::cfg_type   cfg,
   input  rop_pkg::pixel_type dst_pixel,
   input  rop_pkg::pixel_type src_pixel,
   input  rop_pkg::pixel_type tile_pixel,
   output rop_pkg::pixel_type result_pixel,
   output logic               write_enable
);
   import rop_pkg::*;

   pixel_type depth_mask;
   pixel_type key_mask;
   pixel_type operand;
   pixel_type rop_out;
   pixel_type raw;

   always_comb begin
      case (cfg.pixel_depth)
         DEPTH_8: begin
            depth_mask = MASK_8;
            key_mask   = MASK_8;
         end
         DEPTH_16: begin
            depth_mask = MASK_16;
            key_mask   = MASK_16;
         end
         default: begin
            depth_mask = MASK_32;
            key_mask   = KEY_MASK_24;
         end
      endcase

      case (cfg.source_kind)
         SRC_SOLID: operand = cfg.reference_color;
         SRC_TILE:  operand = tile_pixel;
         default:   operand = src_pixel;
      endcase

      // truth table bit picked by inverted source and destination bits
      rop_out = ({PIXEL_BITS{cfg.rop_code[0]}} &  operand &  dst_pixel)
              | ({PIXEL_BITS{cfg.rop_code[1]}} &  operand & ~dst_pixel)
              | ({PIXEL_BITS{cfg.rop_code[2]}} & ~operand &  dst_pixel)
              | ({PIXEL_BITS{cfg.rop_code[3]}} & ~operand & ~dst_pixel);

      raw          = rop_out;
      write_enable = 1'b1;
      if (cfg.source_kind == SRC_KEYED) begin
         if ((src_pixel & key_mask) != (cfg.reference_color & key_mask)) begin
            raw = src_pixel;
         end else begin
            raw          = dst_pixel;
            write_enable = 1'b0;
         end
      end
      result_pixel = raw & depth_mask;
   end

endmodule

`default_nettype wire

// ----- hdl/raster_op_pixel_blitter.sv -----
// Per-pixel raster-op blitter: each pixel item gives one result item after it is accepted, and a
// new item (pixel or tile-load) can be accepted every clock, so the block sustains one pixel
// per cycle; the only stall comes from back-pressure on the result side. A pixel passes
// through the synchronous read of the single-port-read tile store, which runs in the accept
// cycle from the tile walker's address, and then through the raster-op logic into the result
// register. Tile-load items write the store and return no result; loads to an address beyond
// the store are dropped. TILE_PIXELS must be a power of two (16 to 65536); the tile walker
// wraps its addresses modulo that size. Configuration writes are taken every cycle outside
// reset and must land only while no pixel is in flight.
`default_nettype none
`include "raster_op_pixel_blitter_defines.svh"

module raster_op_pixel_blitter #(
   parameter int TILE_PIXELS = 4096
) (
   input  logic      clock,
   input  logic      reset,
   rop_req_if.sink   req_bus,
   rop_rsp_if.source rsp_bus,
   rop_csr_if.sink   csr_bus
);
   import rop_pkg::*;

   localparam int AW   = $clog2(TILE_PIXELS);
   localparam int WA_W = (AW > TILE_ADDR_BITS) ? AW : TILE_ADDR_BITS;

   cfg_type      cfg_ff, cfg_in;
   logic         csr_write;
   logic         walk_reload;
   walk_ctl_type walk_ctl;

   logic            req_fire;
   logic            pixel_fire;
   logic            load_item;
   logic            load_fire;
   logic            advance;
   logic            pipe_stalled;
   logic [WA_W-1:0] load_addr_ext;
   logic            load_in_range;
   logic [AW-1:0]   tile_rd_addr;
   pixel_type       tile_rd_data;

   logic      s1_valid_ff, s1_valid_in;
   pixel_type s1_dst_ff;
   pixel_type s1_src_ff;
   logic      s1_eor_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_pixel_ff;
   logic      rsp_we_ff;
   logic      rsp_row_done_ff;

   pixel_type alu_pixel;
   logic      alu_we;

   // configuration registers
   assign csr_bus.ready = !reset;
   assign csr_write     = csr_bus.valid && csr_bus.ready;

   always_comb begin
      cfg_in      = cfg_ff;
      walk_reload = 1'b0;
      if (csr_write) begin
         case (csr_index_type'(csr_bus.index))
            CSR_ROP_CODE:        cfg_in.rop_code        = csr_bus.data[3:0];
            CSR_PIXEL_DEPTH:     cfg_in.pixel_depth     = csr_bus.data[1:0];
            CSR_SOURCE_KIND:     cfg_in.source_kind     = src_kind_type'(csr_bus.data[1:0]);
            CSR_REFERENCE_COLOR: cfg_in.reference_color = csr_bus.data;
            CSR_PAT_WIDTH: begin
               cfg_in.pat_width = csr_bus.data[TILE_DIM_BITS-1:0];
               walk_reload      = 1'b1;
            end
            CSR_PAT_HEIGHT:      cfg_in.pat_height      = csr_bus.data[TILE_DIM_BITS-1:0];
            CSR_PAT_ORIGIN_X: begin
               cfg_in.pat_origin_x = csr_bus.data[TILE_POS_BITS-1:0];
               walk_reload         = 1'b1;
            end
            CSR_PAT_ORIGIN_Y: begin
               cfg_in.pat_origin_y = csr_bus.data[TILE_POS_BITS-1:0];
               walk_reload         = 1'b1;
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input handshake and pipeline control
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign pipe_stalled  = s1_valid_ff && !advance;
   assign req_bus.ready = !reset && (!s1_valid_ff || advance);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign pixel_fire    = req_fire && (req_bus.mode == MODE_PIXEL);
   assign load_item     = req_fire && (req_bus.mode == MODE_TILE_LOAD);

   assign load_addr_ext = WA_W'(req_bus.tile_address);
   assign load_in_range = ({1'b0, load_addr_ext} < (WA_W+1)'(TILE_PIXELS));
   assign load_fire     = load_item && load_in_range;

   assign walk_ctl.reload     = walk_reload;
   assign walk_ctl.step       = pixel_fire;
   assign walk_ctl.end_of_row = req_bus.end_of_row;

   rop_tile_walker #(
      .TILE_PIXELS (TILE_PIXELS)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .cfg_next  (cfg_in),
      .ctl       (walk_ctl),
      .tile_addr (tile_rd_addr)
   );

   rop_tile_store #(
      .TILE_PIXELS (TILE_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (load_addr_ext[AW-1:0]),
      .wr_data (req_bus.src_pixel),
      .rd_en   (pixel_fire),
      .rd_addr (tile_rd_addr),
      .rd_data (tile_rd_data)
   );

   rop_pixel_alu u_alu (
      .cfg          (cfg_ff),
      .dst_pixel    (s1_dst_ff),
      .src_pixel    (s1_src_ff),
      .tile_pixel   (tile_rd_data),
      .result_pixel (alu_pixel),
      .write_enable (alu_we)
   );

   always_comb begin
      s1_valid_in  = pixel_fire || (s1_valid_ff && !advance);
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_fire) begin
         s1_dst_ff <= req_bus.dst_pixel;
         s1_src_ff <= req_bus.src_pixel;
         s1_eor_ff <= req_bus.end_of_row;
      end
      if (advance && s1_valid_ff) begin
         rsp_pixel_ff    <= alu_pixel;
         rsp_we_ff       <= alu_we;
         rsp_row_done_ff <= s1_eor_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.result_pixel = rsp_pixel_ff;
   assign rsp_bus.write_enable = rsp_we_ff;
   assign rsp_bus.row_done     = rsp_row_done_ff;

   // tile-load items never reach the result side
   `ROP_ASSERT_NEXT(a_load_no_result, clock, reset, load_item && !s1_valid_ff, !s1_valid_ff)
   `ROP_ASSERT_NEXT(a_pixel_staged, clock, reset, pixel_fire, s1_valid_ff)
   `ROP_ASSERT_IMPLY(a_full_blocks_input, clock, reset, pipe_stalled, !req_bus.ready)

endmodule

`default_nettype wire
